>>> src/bae_pkg.sv
`default_nettype none
package bae_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SAMPLES_PER_BLOCK = 2'd0;
	localparam logic [1:0] REG_VARIANCE_MODE     = 2'd1;
	localparam logic [1:0] REG_EXPECTED_VALUE    = 2'd2;

	localparam logic [15:0] SPB_RESET = 16'd1000;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_TERM,
		S_ACC,
		S_DIV_MEAN,
		S_SQ_MEAN,
		S_CM_START,
		S_DIV_CM,
		S_DIV_MSQ,
		S_SQ_CM,
		S_DIV_Q,
		S_SQRT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic signed [63:0] val;
		logic               ovf;
	} sadd_t;

	typedef struct packed {
		logic signed [63:0] val;
		logic               sat;
	} sq_t;

	// saturating 64-bit signed add
	function automatic sadd_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		logic signed [64:0] s;
		sadd_t r;
		s = {a[63], a} + {b[63], b};
		r.ovf = (s[64] != s[63]);
		if (r.ovf) begin
			r.val = s[64] ? S64_MIN : S64_MAX;
		end else begin
			r.val = s[63:0];
		end
		return r;
	endfunction

	// (v*v) >> 16 from the full 128-bit square, saturating to the int64 maximum
	function automatic sq_t sq16(input logic [127:0] p);
		sq_t r;
		r.sat = (p[127:79] != '0);
		r.val = r.sat ? S64_MAX : $signed(p[79:16]);
		return r;
	endfunction

	// magnitude of a signed 64-bit value
	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	// divider control between sequencer and divider
	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic [15:0]        den;
	} div_req_t;

endpackage
`default_nettype wire

>>> src/bae_div.sv
`default_nettype none
// Iterative signed 64 / unsigned 16 divider, one quotient bit a cycle,
// truncating toward zero. 64 iterations, then a sign fix-up.
module bae_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bae_pkg::div_req_t req,
	output logic                  done,
	output logic signed [63:0]    quo
);
	import bae_pkg::*;

	logic        busy_q, fin_q, done_q, neg_q;
	logic [5:0]  cnt_q;
	logic [15:0] den_q, rem_q;
	logic [63:0] sh_q;
	logic signed [63:0] quo_q;
	logic [16:0] rem_sh;
	logic        fits;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, sh_q[63]};
		fits   = (rem_sh >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= mag64(req.num);
			neg_q <= req.num[63];
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 16'(rem_sh - {1'b0, den_q}) : rem_sh[15:0];
			sh_q  <= {sh_q[62:0], fits};
		end
		if (fin_q) begin
			quo_q <= neg_q ? $signed(~sh_q + 64'd1) : $signed(sh_q);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

>>> src/block_average_error_top.sv
// Data-blocking mean and standard error.
// A sample that does not close a block is only added to the block sum, in variance mode as a
// squared term from the 32x32 multiplier. A sample that closes a block also runs up to four
// passes of the shared bit-serial divider, up to two 4-step squarings on the multiplier and,
// when needed, a 40-step square root. One sample in flight at a time.
// Reset (arst_n, async, active low) clears all sums and counts and loads register defaults.
`default_nettype none
module block_average_error_top #(
	parameter int MAX_BLOCKS = 65535
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_write,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,  // sample[31:0]
	input  wire logic [0:0]   s_tuser,  // restart[0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// blocks_done[15:0], cumulative_mean[63:16], std_error[111:64], saturated[112], zero pad
	output logic [119:0]      m_tdata
);
	import bae_pkg::*;

	localparam logic [15:0] MAXB = 16'(MAX_BLOCKS);

	state_t state_q, state_d;

	// configuration
	logic [15:0]        spb_q;
	logic               var_q;
	logic signed [31:0] ev_q;

	// statistics state
	logic [15:0]        cnt_q, bc_q;
	logic signed [63:0] acc_q, msum_q, mssq_q;
	logic               ovf_q;

	// working registers
	logic signed [31:0] s_q;
	logic signed [63:0] term_q, ss_q, mean_q, cm_q, msq_q;
	logic [63:0]        sqa_q, p_q;
	logic [127:0]       sq_q;
	logic [1:0]         step_q;
	logic [79:0]        rad_q;
	logic [41:0]        rem_q;
	logic [39:0]        root_q;
	logic [5:0]         it_q;
	logic [47:0]        err_q;

	// output register
	logic               ov_q;
	logic [15:0]        o_bd_q;
	logic [47:0]        o_cm_q, o_err_q;
	logic               o_sat_q;

	logic        accept, out_load, div_done;
	logic signed [63:0] div_quo;
	div_req_t    dreq;
	logic [31:0] mul_x, mul_y;
	logic [15:0] size, cnt_n, n_blk;
	sadd_t       acc_n;
	logic [127:0] sq_n;
	sq_t         sqr;
	logic signed [63:0] diff_d;
	logic [43:0] rem_sh;
	logic [41:0] trial;
	logic        rfit;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!ov_q || m_tready);

	assign size  = (spb_q == '0) ? 16'd1 : spb_q;
	assign cnt_n = cnt_q + 16'd1;
	assign acc_n = sat_add(acc_q, term_q);
	assign n_blk = (bc_q == '0) ? 16'd1 : bc_q;

	// square accumulation step and result
	always_comb begin
		case (step_q)
			2'd1:    sq_n = sq_q + {64'd0, p_q};
			2'd2:    sq_n = sq_q + {31'd0, p_q, 33'd0};
			2'd3:    sq_n = sq_q + {p_q, 64'd0};
			default: sq_n = '0;
		endcase
		sqr    = sq16(sq_n);
		diff_d = msq_q - sqr.val;
	end

	// square-root step
	always_comb begin
		rem_sh = {rem_q, rad_q[79:78]};
		trial  = {root_q, 2'b01};
		rfit   = (rem_sh >= {2'b00, trial});
	end

	// shared multiplier operands
	always_comb begin
		mul_x = '0;
		mul_y = '0;
		case (state_q)
			S_TERM: begin
				if (step_q == 2'd0) begin
					mul_x = s_q[31] ? (~s_q + 32'd1) : s_q;
				end else begin
					mul_x = ev_q[31] ? (~ev_q + 32'd1) : ev_q;
				end
				mul_y = mul_x;
			end
			S_SQ_MEAN, S_SQ_CM: begin
				mul_x = (step_q == 2'd2) ? sqa_q[63:32] : sqa_q[31:0];
				mul_y = (step_q == 2'd0) ? sqa_q[31:0] : sqa_q[63:32];
			end
			default: ;
		endcase
	end

	// divider requests
	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = acc_n.val;
		dreq.den   = size;
		case (state_q)
			S_ACC: dreq.start = (cnt_n >= size);
			S_CM_START: begin
				dreq.start = 1'b1;
				dreq.num   = msum_q;
				dreq.den   = n_blk;
			end
			S_DIV_CM: begin
				dreq.start = div_done;
				dreq.num   = mssq_q;
				dreq.den   = n_blk;
			end
			S_SQ_CM: begin
				dreq.start = (step_q == 2'd3) && (diff_d > 0);
				dreq.num   = diff_d;
				dreq.den   = n_blk - 16'd1;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (accept) state_d = s_tuser[0] | ~var_q ? (var_q ? S_TERM : S_ACC)
				: S_TERM;
			S_TERM:     if (step_q == 2'd2) state_d = S_ACC;
			S_ACC:      state_d = (cnt_n >= size) ? S_DIV_MEAN : S_IDLE;
			S_DIV_MEAN: if (div_done) state_d = (bc_q >= MAXB) ? S_CM_START : S_SQ_MEAN;
			S_SQ_MEAN:  if (step_q == 2'd3) state_d = S_CM_START;
			S_CM_START: state_d = S_DIV_CM;
			S_DIV_CM:   if (div_done) state_d = S_DIV_MSQ;
			S_DIV_MSQ:  if (div_done) state_d = (n_blk > 16'd1) ? S_SQ_CM : S_OUT;
			S_SQ_CM:    if (step_q == 2'd3) state_d = (diff_d > 0) ? S_DIV_Q : S_OUT;
			S_DIV_Q:    if (div_done) state_d = S_SQRT;
			S_SQRT:     if (it_q == 6'd39) state_d = S_OUT;
			S_OUT:      if (out_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// control state, configuration and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			spb_q   <= SPB_RESET;
			var_q   <= 1'b0;
			ev_q    <= '0;
			cnt_q   <= '0;
			bc_q    <= '0;
			acc_q   <= '0;
			msum_q  <= '0;
			mssq_q  <= '0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
			step_q  <= '0;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					REG_SAMPLES_PER_BLOCK: spb_q <= cfg_data[15:0];
					REG_VARIANCE_MODE:     var_q <= cfg_data[0];
					REG_EXPECTED_VALUE:    ev_q  <= cfg_data;
					default: ;
				endcase
			end
			step_q <= (state_d == state_q) ? step_q + 2'd1 : 2'd0;
			it_q   <= (state_q == S_SQRT) ? it_q + 6'd1 : 6'd0;
			case (state_q)
				S_IDLE: begin
					if (accept && s_tuser[0]) begin
						cnt_q  <= '0;
						bc_q   <= '0;
						acc_q  <= '0;
						msum_q <= '0;
						mssq_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				S_ACC: begin
					if (acc_n.ovf) ovf_q <= 1'b1;
					if (cnt_n >= size) begin
						cnt_q <= '0;
						acc_q <= '0;
					end else begin
						cnt_q <= cnt_n;
						acc_q <= acc_n.val;
					end
				end
				S_DIV_MEAN: begin
					if (div_done && bc_q >= MAXB) ovf_q <= 1'b1;
				end
				S_SQ_MEAN: begin
					if (step_q == 2'd3) begin : upd
						sadd_t ms, mq;
						ms = sat_add(msum_q, mean_q);
						mq = sat_add(mssq_q, sqr.val);
						bc_q   <= bc_q + 16'd1;
						msum_q <= ms.val;
						mssq_q <= mq.val;
						if (ms.ovf || mq.ovf || sqr.sat) ovf_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// working datapath
	always_ff @(posedge clk) begin
		p_q <= mul_x * mul_y;
		case (state_q)
			S_IDLE: begin
				s_q    <= $signed(s_tdata);
				term_q <= 64'(signed'(s_tdata));
			end
			S_TERM: begin
				if (step_q == 2'd1) ss_q <= $signed(p_q);
				if (step_q == 2'd2) term_q <= (ss_q - $signed(p_q)) >>> 16;
			end
			S_DIV_MEAN: begin
				mean_q <= div_quo;
				sqa_q  <= mag64(div_quo);
			end
			S_SQ_MEAN, S_SQ_CM: begin
				sq_q  <= sq_n;
				err_q <= '0;
			end
			S_DIV_CM: cm_q <= div_quo;
			S_DIV_MSQ: begin
				msq_q <= div_quo;
				sqa_q <= mag64(cm_q);
				err_q <= '0;
			end
			S_DIV_Q: begin
				rad_q  <= {div_quo, 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				rad_q  <= {rad_q[77:0], 2'b00};
				rem_q  <= rfit ? 42'(rem_sh - {2'b00, trial}) : rem_sh[41:0];
				root_q <= {root_q[38:0], rfit};
				if (it_q == 6'd39) err_q <= {8'd0, root_q[38:0], rfit};
			end
			default: ;
		endcase
		if (out_load) begin
			o_bd_q  <= bc_q;
			o_sat_q <= ovf_q;
			o_err_q <= err_q;
			if (cm_q[63:47] == '0 || cm_q[63:47] == '1) begin
				o_cm_q <= cm_q[47:0];
			end else begin
				o_cm_q <= cm_q[63] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
			end
		end
	end

	bae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign m_tvalid = ov_q;
	assign m_tdata  = {7'd0, o_sat_q, o_err_q, o_cm_q, o_bd_q};

endmodule
`default_nettype wire

>>> src/bae_checker.sv
`default_nettype none
module bae_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [119:0] m_tdata
);

	// one sample in flight: input closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transaction");

	// a waiting result keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every result counts at least one block
	a_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] != 16'd0)
		else $error("result with zero blocks");

	// after the first block the error is zero and the pad bits are clear
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] == 16'd1 |-> m_tdata[111:64] == 48'd0
			&& m_tdata[119:113] == 7'd0)
		else $error("nonzero error after first block");

endmodule

bind block_average_error_top bae_checker u_bae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
